// File: rtl/tapm_pkg.sv
// Shared types, constants and codes of the two-axis proportional move controller.
`timescale 1ns / 1ps

package tapm_pkg;

  localparam int POSITION_BITS = 16;
  localparam int DELTA_BITS    = POSITION_BITS + 1;
  localparam int POWER_BITS    = 7;
  localparam int DRIVE_BITS    = 8;
  localparam int QUOTIENT_BITS = 8;
  localparam int LFB_DEFAULT   = 8;

  localparam logic [POWER_BITS-1:0] POWER_RESET = POWER_BITS'(50);

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef struct packed {
    logic                            opcode;
    logic signed [POSITION_BITS-1:0] target_x;
    logic signed [POSITION_BITS-1:0] target_y;
    logic signed [POSITION_BITS-1:0] enc_x;
    logic signed [POSITION_BITS-1:0] enc_y;
    logic                            stop_pressed;
  } in_word_t;

  typedef struct packed {
    logic signed [DRIVE_BITS-1:0] power_x;
    logic signed [DRIVE_BITS-1:0] power_y;
    logic                         moving;
    logic                         halted;
  } out_word_t;

  typedef struct packed {
    logic                         done;
    logic signed [DRIVE_BITS-1:0] power_x;
    logic signed [DRIVE_BITS-1:0] power_y;
  } calc_res_t;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_SQX,
    CS_SQY,
    CS_SUM,
    CS_ROOT,
    CS_PROD,
    CS_LOAD,
    CS_DIV,
    CS_DONE
  } calc_state_t;

endpackage

// File: rtl/tapm_calc.sv
// Sequenced power calculation: squares, integer square root and rounded divide on shared units.
`timescale 1ns / 1ps

module tapm_calc #(
  parameter int FRAC_BITS = tapm_pkg::LFB_DEFAULT
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  input  logic                                    ack,
  input  logic signed [tapm_pkg::DELTA_BITS-1:0]  dx,
  input  logic signed [tapm_pkg::DELTA_BITS-1:0]  dy,
  input  logic        [tapm_pkg::POWER_BITS-1:0]  movement_power,
  output tapm_pkg::calc_res_t                     res
);
  import tapm_pkg::*;

  localparam int D     = DELTA_BITS;
  localparam int PW    = 2 * D;
  localparam int NW    = PW + 2 * FRAC_BITS;
  localparam int ITER  = D + FRAC_BITS;
  localparam int LW    = ITER;
  localparam int RW    = LW + 3;
  localparam int QB    = QUOTIENT_BITS;
  localparam int DVW   = D + POWER_BITS + FRAC_BITS + 1;
  localparam int DSW   = LW + QB - 1;
  localparam int SUBW  = (DVW > RW) ? DVW : RW;
  localparam int CW    = $clog2(ITER + 1);

  calc_state_t state, state_next;

  logic              axis;
  logic [CW-1:0]     cnt;
  logic [D-1:0]      mag_x, mag_y;
  logic              neg_x, neg_y;
  logic [PW-1:0]     prod, acc;
  logic [NW-1:0]     rad;
  logic [RW-1:0]     rem_r;
  logic [LW-1:0]     root;
  logic [DVW-1:0]    dvd;
  logic [DSW-1:0]    dsh;
  logic [QB-1:0]     quo, qx;

  logic [D-1:0]      mul_a, mul_b;
  logic [PW-1:0]     mul_p;
  logic [PW-1:0]     sum_sq;
  logic [RW-1:0]     r_sh, trial;
  logic [SUBW-1:0]   sub_a, sub_b;
  logic [SUBW:0]     diff;
  logic              ge;
  logic              last;
  logic [D-1:0]      abs_dx, abs_dy;

  assign abs_dx = dx[D-1] ? D'(-dx) : D'(dx);
  assign abs_dy = dy[D-1] ? D'(-dy) : D'(dy);

  assign mul_a = (state == CS_SQY || (state == CS_PROD && axis)) ? mag_y : mag_x;
  assign mul_b = (state == CS_PROD) ? D'(movement_power) : mul_a;
  assign mul_p = mul_a * mul_b;
  assign sum_sq = acc + prod;

  assign r_sh  = {rem_r[RW-3:0], rad[NW-1 -: 2]};
  assign trial = RW'({root, 2'b01});
  assign sub_a = (state == CS_ROOT) ? SUBW'(r_sh) : SUBW'(dvd);
  assign sub_b = (state == CS_ROOT) ? SUBW'(trial) : SUBW'(dsh);
  assign diff  = {1'b0, sub_a} - {1'b0, sub_b};
  assign ge    = ~diff[SUBW];
  assign last  = (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      CS_IDLE: if (start) state_next = CS_SQX;
      CS_SQX:  state_next = CS_SQY;
      CS_SQY:  state_next = CS_SUM;
      CS_SUM:  state_next = CS_ROOT;
      CS_ROOT: if (last) state_next = CS_PROD;
      CS_PROD: state_next = CS_LOAD;
      CS_LOAD: state_next = CS_DIV;
      CS_DIV:  if (last) state_next = axis ? CS_DONE : CS_PROD;
      CS_DONE: if (ack) state_next = CS_IDLE;
      default: state_next = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      CS_IDLE: begin
        if (start) begin
          mag_x <= abs_dx;
          mag_y <= abs_dy;
          neg_x <= dx[D-1];
          neg_y <= dy[D-1];
          axis  <= 1'b0;
        end
      end
      CS_SQX: begin
        prod <= mul_p;
      end
      CS_SQY: begin
        prod <= mul_p;
        acc  <= prod;
      end
      CS_SUM: begin
        rad   <= NW'(sum_sq) << (2 * FRAC_BITS);
        rem_r <= '0;
        root  <= '0;
        cnt   <= CW'(ITER - 1);
      end
      CS_ROOT: begin
        rad   <= rad << 2;
        rem_r <= ge ? diff[RW-1:0] : r_sh;
        root  <= {root[LW-2:0], ge};
        cnt   <= cnt - 1'b1;
      end
      CS_PROD: begin
        prod <= mul_p;
      end
      CS_LOAD: begin
        dvd <= (DVW'(prod[D+POWER_BITS-1:0]) << FRAC_BITS) + DVW'(root >> 1);
        dsh <= DSW'(root) << (QB - 1);
        quo <= '0;
        cnt <= CW'(QB - 1);
      end
      CS_DIV: begin
        if (ge) begin
          dvd <= diff[DVW-1:0];
        end
        quo <= {quo[QB-2:0], ge};
        dsh <= dsh >> 1;
        cnt <= cnt - 1'b1;
        if (last) begin
          if (!axis) begin
            qx <= {quo[QB-2:0], ge};
          end
          axis <= 1'b1;
        end
      end
      CS_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.done    = (state == CS_DONE);
    res.power_x = (mag_x == '0) ? '0 : (neg_x ? DRIVE_BITS'(-qx) : DRIVE_BITS'(qx));
    res.power_y = (mag_y == '0) ? '0 : (neg_y ? DRIVE_BITS'(-quo) : DRIVE_BITS'(quo));
  end

endmodule

// File: rtl/two_axis_proportional_move.sv
// Top level of the two-axis proportional move controller.
//
// Input words arrive on item_valid/item_ready. A start word latches the target
// and takes the encoder counts as origin; a tick word checks each axis for
// arrival. Every input word gives exactly one result word on
// result_valid/result_ready, carrying both axis powers, the moving flag and the
// sticky halted flag. The path speed is written on cfg_valid/cfg_ready/cfg_data,
// which is always ready; write it only while the block is idle.
// A tick word, a stop word or a start word while halted yields its result in
// the cycle after acceptance. A start word runs a sequenced calculation: the
// two squares and their sum, the bit-serial square root, and per axis the
// product and the eight-step divide, all on one multiplier and one subtractor.
// Its result is registered once the calculation is done and no earlier result
// waits untaken, and no word is taken meanwhile.
// A new word is accepted while a finished result waits only if the receiver
// takes that result in the same cycle; a stalled receiver holds the block.
// Synchronous reset clears the move, the halted flag and the result valid flag,
// and returns the path speed to 50.
`timescale 1ns / 1ps

module two_axis_proportional_move #(
  parameter int LENGTH_FRACTION_BITS = tapm_pkg::LFB_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  tapm_pkg::in_word_t                   item,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output tapm_pkg::out_word_t                  result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tapm_pkg::POWER_BITS-1:0]      cfg_data
);
  import tapm_pkg::*;

  logic                            busy;
  logic                            stopped_flag, stopped_flag_next;
  logic                            x_positive, x_positive_next;
  logic                            y_positive, y_positive_next;
  logic                            x_running, x_running_next;
  logic                            y_running, y_running_next;
  logic signed [POSITION_BITS-1:0] goal_x, goal_x_next;
  logic signed [POSITION_BITS-1:0] goal_y, goal_y_next;
  logic signed [DRIVE_BITS-1:0]    drive_x, drive_x_next;
  logic signed [DRIVE_BITS-1:0]    drive_y, drive_y_next;
  logic [POWER_BITS-1:0]           movement_power;

  logic                            accept, launch, ack, load;
  logic                            slot_free;
  logic signed [DELTA_BITS-1:0]    dx, dy;
  calc_res_t                       res;
  out_word_t                       word_next;

  assign slot_free  = !result_valid || result_ready;
  assign item_ready = !busy && slot_free;
  assign cfg_ready  = 1'b1;
  assign accept     = item_valid && item_ready;
  assign launch     = accept && !item.stop_pressed && !stopped_flag && item.opcode == OP_START;
  assign ack        = res.done && slot_free;
  assign load       = (accept && !launch) || ack;

  assign dx = DELTA_BITS'(item.target_x) - DELTA_BITS'(item.enc_x);
  assign dy = DELTA_BITS'(item.target_y) - DELTA_BITS'(item.enc_y);

  tapm_calc #(
    .FRAC_BITS(LENGTH_FRACTION_BITS)
  ) u_calc (
    .clk            (clk),
    .rst            (rst),
    .start          (launch),
    .ack            (ack),
    .dx             (dx),
    .dy             (dy),
    .movement_power (movement_power),
    .res            (res)
  );

  always_comb begin
    stopped_flag_next = stopped_flag;
    x_positive_next   = x_positive;
    y_positive_next   = y_positive;
    x_running_next    = x_running;
    y_running_next    = y_running;
    goal_x_next       = goal_x;
    goal_y_next       = goal_y;
    drive_x_next      = drive_x;
    drive_y_next      = drive_y;
    if (accept) begin
      if (item.stop_pressed) begin
        stopped_flag_next = 1'b1;
        x_running_next    = 1'b0;
        y_running_next    = 1'b0;
        drive_x_next      = '0;
        drive_y_next      = '0;
      end else if (!stopped_flag) begin
        if (item.opcode == OP_START) begin
          goal_x_next     = item.target_x;
          goal_y_next     = item.target_y;
          x_positive_next = !dx[DELTA_BITS-1] && dx != '0;
          y_positive_next = !dy[DELTA_BITS-1] && dy != '0;
          x_running_next  = dx != '0;
          y_running_next  = dy != '0;
        end else begin
          if (x_running && (x_positive ? item.enc_x >= goal_x : item.enc_x <= goal_x)) begin
            x_running_next = 1'b0;
            drive_x_next   = '0;
          end
          if (y_running && (y_positive ? item.enc_y >= goal_y : item.enc_y <= goal_y)) begin
            y_running_next = 1'b0;
            drive_y_next   = '0;
          end
        end
      end
    end
    if (ack) begin
      drive_x_next = res.power_x;
      drive_y_next = res.power_y;
    end
    word_next.power_x = x_running_next ? drive_x_next : '0;
    word_next.power_y = y_running_next ? drive_y_next : '0;
    word_next.moving  = x_running_next || y_running_next;
    word_next.halted  = stopped_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      stopped_flag   <= 1'b0;
      x_positive     <= 1'b0;
      y_positive     <= 1'b0;
      x_running      <= 1'b0;
      y_running      <= 1'b0;
      goal_x         <= '0;
      goal_y         <= '0;
      drive_x        <= '0;
      drive_y        <= '0;
      movement_power <= POWER_RESET;
      result_valid   <= 1'b0;
    end else begin
      stopped_flag <= stopped_flag_next;
      x_positive   <= x_positive_next;
      y_positive   <= y_positive_next;
      x_running    <= x_running_next;
      y_running    <= y_running_next;
      goal_x       <= goal_x_next;
      goal_y       <= goal_y_next;
      drive_x      <= drive_x_next;
      drive_y      <= drive_y_next;
      if (launch) begin
        busy <= 1'b1;
      end else if (ack) begin
        busy <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        movement_power <= cfg_data;
      end
      if (load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= word_next;
    end
  end

endmodule

// File: dv/move_checker.sv
// Checker that predicts every result word of the move controller and compares it with the block.
`timescale 1ns / 1ps

module move_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  input  logic                            item_ready,
  input  tapm_pkg::in_word_t              item,
  input  logic                            result_valid,
  input  logic                            result_ready,
  input  tapm_pkg::out_word_t             result,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [tapm_pkg::POWER_BITS-1:0] cfg_data,
  output int unsigned                     fail_count,
  output int unsigned                     pending
);
  import tapm_pkg::*;

  localparam int FRAC = LFB_DEFAULT;

  logic signed [POSITION_BITS-1:0] aim_x, aim_y;
  logic                            up_x, up_y, run_x, run_y, halted_now;
  logic signed [DRIVE_BITS-1:0]    drv_x, drv_y;
  logic [POWER_BITS-1:0]           speed;
  out_word_t                       motor_words[$];
  out_word_t                       oldest;

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned root, probe;
    root = 0;
    probe = 64'd1 << 62;
    while (probe > n) probe = probe >> 2;
    while (probe != 0) begin
      if (n >= root + probe) begin
        n = n - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // Power along one axis: its share of the path speed, rounded to nearest.
  function automatic logic signed [DRIVE_BITS-1:0] axis_drive(longint signed d,
                                                              longint unsigned length);
    longint unsigned span, q;
    if (d == 0 || length == 0) return '0;
    span = (d < 0) ? -d : d;
    q = (span * speed) << FRAC;
    q = (q + length / 2) / length;
    return (d < 0) ? DRIVE_BITS'(-q) : DRIVE_BITS'(q);
  endfunction

  function automatic out_word_t motor_response(in_word_t w);
    longint signed   dx, dy;
    longint unsigned mx, my, length;
    out_word_t       r;
    if (w.stop_pressed) begin
      halted_now = 1'b1;
      run_x = 1'b0;
      run_y = 1'b0;
      drv_x = '0;
      drv_y = '0;
    end else if (!halted_now) begin
      if (w.opcode == OP_START) begin
        aim_x = w.target_x;
        aim_y = w.target_y;
        dx = longint'(w.target_x) - longint'(w.enc_x);
        dy = longint'(w.target_y) - longint'(w.enc_y);
        mx = (dx < 0) ? -dx : dx;
        my = (dy < 0) ? -dy : dy;
        length = floor_root((mx * mx + my * my) << (2 * FRAC));
        up_x = dx > 0;
        up_y = dy > 0;
        run_x = dx != 0;
        run_y = dy != 0;
        drv_x = axis_drive(dx, length);
        drv_y = axis_drive(dy, length);
      end else begin
        if (run_x && (up_x ? (w.enc_x >= aim_x) : (w.enc_x <= aim_x))) begin
          run_x = 1'b0;
          drv_x = '0;
        end
        if (run_y && (up_y ? (w.enc_y >= aim_y) : (w.enc_y <= aim_y))) begin
          run_y = 1'b0;
          drv_y = '0;
        end
      end
    end
    r.power_x = run_x ? drv_x : '0;
    r.power_y = run_y ? drv_y : '0;
    r.moving  = run_x || run_y;
    r.halted  = halted_now;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      aim_x = '0;
      aim_y = '0;
      up_x = 1'b0;
      up_y = 1'b0;
      run_x = 1'b0;
      run_y = 1'b0;
      drv_x = '0;
      drv_y = '0;
      halted_now = 1'b0;
      speed = POWER_RESET;
      motor_words.delete();
      fail_count = 0;
    end else begin
      if (result_valid && result_ready) begin
        if (motor_words.size() == 0) begin
          $error("result word with no prediction waiting: %p", result);
          fail_count++;
        end else begin
          oldest = motor_words.pop_front();
          if (result.power_x !== oldest.power_x) begin
            $error("power_x: expected %0d, actual %0d", oldest.power_x, result.power_x);
            fail_count++;
          end
          if (result.power_y !== oldest.power_y) begin
            $error("power_y: expected %0d, actual %0d", oldest.power_y, result.power_y);
            fail_count++;
          end
          if (result.moving !== oldest.moving) begin
            $error("moving: expected %0d, actual %0d", oldest.moving, result.moving);
            fail_count++;
          end
          if (result.halted !== oldest.halted) begin
            $error("halted: expected %0d, actual %0d", oldest.halted, result.halted);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) speed = cfg_data;
      if (item_valid && item_ready) motor_words.push_back(motor_response(item));
    end
    pending = motor_words.size();
  end

endmodule

// File: dv/tb_top.sv
// Testbench top for the two-axis move controller: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_top;
  import tapm_pkg::*;

  localparam int STALL_LIMIT     = 3000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 60;
  localparam int RANDOM_ITEMS    = 1300;
  localparam int PHASES          = 6;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  item_valid, item_ready;
  in_word_t              item;
  logic                  result_valid, result_ready;
  out_word_t             result;
  logic                  cfg_valid, cfg_ready;
  logic [POWER_BITS-1:0] cfg_data;
  int unsigned           fail_count, pending;
  int unsigned           send_idle_pct = 0;
  int unsigned           recv_idle_pct = 0;
  int unsigned           words_offered = 0;
  int unsigned           stall_cycles = 0;
  logic                  hold_off_req = 1'b0;
  logic                  hold_off_done = 1'b0;
  logic [POWER_BITS-1:0] phase_speed [PHASES] = '{7'd100, 7'd10, 7'd127, 7'd0, 7'd64, 7'd33};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  two_axis_proportional_move uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  move_checker watch (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // The receiver holds off once for a long stretch so that the block backs up.
  initial begin
    result_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        result_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
      end else begin
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("two_axis_proportional_move test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic int rand16();
    return int'($urandom_range(65535)) - 32768;
  endfunction

  function automatic int clamp16(int v);
    return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
  endfunction

  function automatic int wobble();
    return int'($urandom_range(10)) - 5;
  endfunction

  function automatic int pick_delta();
    int m;
    case ($urandom_range(9))
      0: return 0;
      1: return rand16() - rand16();
      2, 3: m = $urandom_range(16, 1);
      default: m = $urandom_range(3000, 1);
    endcase
    return $urandom_range(1) ? m : -m;
  endfunction

  // Last reading of a move on one axis: an exact hit, an overshoot or falling short.
  function automatic int finish_at(int goal, int delta);
    int dir;
    dir = (delta > 0) ? 1 : ((delta < 0) ? -1 : 0);
    case ($urandom_range(2))
      0: return goal;
      1: return clamp16(goal + dir * int'($urandom_range(20, 1)));
      default: return clamp16(goal - dir * int'($urandom_range(20, 1)));
    endcase
  endfunction

  task automatic offer(logic op, int tx, int ty, int ex, int ey, logic stop);
    in_word_t w;
    w.opcode       = op;
    w.target_x     = POSITION_BITS'(tx);
    w.target_y     = POSITION_BITS'(ty);
    w.enc_x        = POSITION_BITS'(ex);
    w.enc_y        = POSITION_BITS'(ey);
    w.stop_pressed = stop;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= w;
    do @(posedge clk); while (!item_ready);
    words_offered++;
  endtask

  task automatic run_move();
    int sx, sy, gx, gy, dx, dy, steps, k;
    sx = rand16();
    sy = rand16();
    gx = clamp16(sx + pick_delta());
    gy = clamp16(sy + pick_delta());
    dx = gx - sx;
    dy = gy - sy;
    offer(OP_START, gx, gy, sx, sy, 1'b0);
    steps = $urandom_range(8, 1);
    for (k = 1; k < steps; k++) begin
      offer(OP_TICK, rand16(), rand16(), clamp16(sx + dx * k / steps + wobble()),
            clamp16(sy + dy * k / steps + wobble()), 1'b0);
    end
    offer(OP_TICK, rand16(), rand16(), finish_at(gx, dx), finish_at(gy, dy), 1'b0);
    if ($urandom_range(3) == 0) begin
      offer(OP_TICK, rand16(), rand16(), clamp16(gx + wobble()), clamp16(gy + wobble()), 1'b0);
    end
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  task automatic write_speed(logic [POWER_BITS-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned quota;
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    send_idle_pct = 19;
    recv_idle_pct <= 74;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed words at the reset path speed.
    offer(OP_TICK, 0, 0, 0, 0, 1'b0);
    offer(OP_START, 100, -100, 100, -100, 1'b0);
    offer(OP_START, 5, 1000, 5, 0, 1'b0);
    offer(OP_TICK, 0, 0, 5, 1000, 1'b0);
    offer(OP_START, 32767, 32767, -32768, -32768, 1'b0);
    offer(OP_TICK, -32768, -32768, 32767, 0, 1'b0);
    offer(OP_TICK, 0, 0, 32767, 32767, 1'b0);
    offer(OP_START, -32768, -32768, 32767, 32767, 1'b0);
    offer(OP_TICK, 0, 0, -32768, 100, 1'b0);
    offer(OP_TICK, 0, 0, -32768, -32768, 1'b0);
    offer(OP_START, 32767, -32768, -32768, 32767, 1'b0);
    offer(OP_START, 1, 2, 0, 0, 1'b0);
    offer(OP_TICK, 0, 0, 3, 5, 1'b0);
    offer(OP_START, 3, 4, 0, 0, 1'b0);
    offer(OP_TICK, 0, 0, 2, 3, 1'b0);
    offer(OP_TICK, 0, 0, -1, -1, 1'b0);
    offer(OP_TICK, 0, 0, 3, 3, 1'b0);
    offer(OP_START, 1, 0, 0, 0, 1'b0);
    offer(OP_TICK, 0, 0, 1, 0, 1'b0);
    offer(OP_START, -1, -1, 0, 0, 1'b0);
    offer(OP_TICK, 0, 0, -1, -2, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_speed(phase_speed[p]);
      case (p / 2)
        0: begin
          send_idle_pct = 19;
          recv_idle_pct <= 74;
        end
        1: begin
          send_idle_pct = 74;
          recv_idle_pct <= 19;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      if (p == 4) hold_off_req <= 1'b1;
      quota = words_offered + RANDOM_ITEMS / PHASES;
      while (words_offered < quota) begin
        if ($urandom_range(99) < 15) begin
          offer(1'($urandom_range(1)), rand16(), rand16(), rand16(), rand16(), 1'b0);
        end else begin
          run_move();
        end
      end
    end

    // The stop button is sticky until reset, so it is pressed only at the very end.
    offer(OP_START, 2000, -1500, 0, 0, 1'b0);
    offer(OP_TICK, 0, 0, 500, -300, 1'b0);
    offer(OP_TICK, 0, 0, 600, -400, 1'b1);
    offer(OP_START, 100, 100, 0, 0, 1'b0);
    offer(OP_TICK, 0, 0, 2000, -1500, 1'b0);
    offer(OP_START, 5, 5, 0, 0, 1'b1);
    offer(OP_TICK, 0, 0, 7, 7, 1'b0);

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("two_axis_proportional_move test passed");
    end else begin
      $display("two_axis_proportional_move test failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/tapm_pkg.sv
rtl/tapm_calc.sv
rtl/two_axis_proportional_move.sv
dv/move_checker.sv
dv/tb_top.sv
